### hdl/dhcp_option_stream_parser_core_defines.svh
// Assertion macros shared by the DHCP option stream parser RTL.
// Depends on nothing; included by the top level.
`ifndef DHCP_OPTION_STREAM_PARSER_CORE_DEFINES_SVH
`define DHCP_OPTION_STREAM_PARSER_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DOSP_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DOSP_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### hdl/dosp_pkg.sv
// Types and constants of the DHCP option stream parser.
// No dependencies; used by every module of the block.
`default_nettype none
package dosp_pkg;
   typedef enum logic [3:0] {
      PH_IDLE, PH_HEAD, PH_TYPE, PH_LEN, PH_VAL, PH_RCODE, PH_RLEN, PH_RVAL, PH_RSKIP
   } phase_type;

   localparam logic [3:0] KIND_VERDICT = 4'd0;
   localparam logic [3:0] KIND_MSGTYPE = 4'd1;
   localparam logic [3:0] KIND_REQIP = 4'd2;
   localparam logic [3:0] KIND_HOST = 4'd3;
   localparam logic [3:0] KIND_VENDOR = 4'd4;
   localparam logic [3:0] KIND_AUTHHDR = 4'd5;
   localparam logic [3:0] KIND_REPLAY = 4'd6;
   localparam logic [3:0] KIND_AUTHINFO = 4'd7;
   localparam logic [3:0] KIND_CIRCUIT = 4'd8;
   localparam logic [3:0] KIND_REMOTE = 4'd9;
   localparam logic [3:0] KIND_WARNING = 4'd10;

   localparam logic [31:0] WARN_STEPS = 32'd1;
   localparam logic [31:0] WARN_TRUNC = 32'd2;
   localparam logic [31:0] WARN_OVERRUN = 32'd3;

   localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
   localparam logic [15:0] HEADER_BYTES = 16'd240;
   localparam logic [15:0] COOKIE_LAST_POS = 16'd239;
   localparam logic [7:0] OPT_PAD = 8'd0;
   localparam logic [7:0] OPT_END = 8'd255;
   localparam logic [7:0] OPT_MSGTYPE = 8'd53;
   localparam logic [7:0] OPT_REQIP = 8'd50;
   localparam logic [7:0] OPT_HOST = 8'd12;
   localparam logic [7:0] OPT_VENDOR = 8'd60;
   localparam logic [7:0] OPT_RELAY = 8'd82;
   localparam logic [7:0] OPT_AUTH = 8'd90;
   localparam logic [7:0] AUTH_MIN_LEN = 8'd11;
   localparam logic [7:0] SUB_CIRCUIT = 8'd1;
   localparam logic [7:0] SUB_REMOTE = 8'd2;
   localparam logic [7:0] PRINT_LOW = 8'h20;
   localparam logic [7:0] PRINT_HIGH = 8'h7E;

   typedef struct packed {
      logic [3:0] kind;
      logic [31:0] value;
      logic [7:0] aux_one;
      logic [7:0] aux_two;
      logic [7:0] byte_index;
      logic last_of_field;
      logic empty_field;
      logic printable;
   } result_type;
endpackage
`default_nettype wire

### hdl/dosp_parse.sv
// Per-byte parse step: state registers and result register.
// Depends on dosp_pkg.
`default_nettype none
module dosp_parse #(
   parameter int MAX_OPTION_STEPS = 200,
   parameter int MAX_SUBOPTIONS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic [7:0] data_byte,
   input  wire logic first_byte,
   input  wire logic [15:0] payload_len,
   input  wire logic [15:0] dest_port,
   input  wire logic is_udp,
   input  wire logic [15:0] server_port,
   input  wire logic [15:0] client_port,
   output logic res_valid,
   output dosp_pkg::result_type res
);
   localparam int SubW = $clog2(MAX_SUBOPTIONS + 1);
   localparam logic [7:0] StepLimit = 8'(MAX_OPTION_STEPS);
   localparam logic [SubW-1:0] SubLimit = SubW'(MAX_SUBOPTIONS);

   dosp_pkg::phase_type phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in, plen_ff, plen_in;
   logic strong_ff, strong_in, reqf_ff, reqf_in, sprn_ff, sprn_in;
   logic [31:0] hdr_ff, hdr_in;
   logic [7:0] steps_ff, steps_in, ocode_ff, ocode_in, olen_ff, olen_in, ooff_ff, ooff_in;
   logic [23:0] gath_ff, gath_in;
   logic [7:0] scode_ff, scode_in, slen_ff, slen_in, soff_ff, soff_in;
   logic [SubW-1:0] scnt_ff, scnt_in;
   logic res_valid_ff, res_valid_in;
   dosp_pkg::result_type res_ff, res_in;

   assign res_valid = res_valid_ff;
   assign res = res_ff;

   always_comb begin
      logic [7:0] b, off;
      logic [15:0] p;
      logic last, named, slast;
      logic [3:0] skind;
      logic [8:0] nsp;
      b = data_byte;
      phase_in = phase_ff; pos_in = pos_ff; plen_in = plen_ff; strong_in = strong_ff;
      reqf_in = reqf_ff; sprn_in = sprn_ff; hdr_in = hdr_ff; steps_in = steps_ff;
      ocode_in = ocode_ff; olen_in = olen_ff; ooff_in = ooff_ff; gath_in = gath_ff;
      scode_in = scode_ff; slen_in = slen_ff; soff_in = soff_ff; scnt_in = scnt_ff;
      res_valid_in = 1'b0;
      res_in = '0;
      p = pos_ff;
      off = ooff_ff;
      last = ({1'b0, off} + 9'd1) >= {1'b0, olen_ff};
      named = scode_ff == dosp_pkg::SUB_CIRCUIT || scode_ff == dosp_pkg::SUB_REMOTE;
      skind = (scode_ff == dosp_pkg::SUB_CIRCUIT) ? dosp_pkg::KIND_CIRCUIT
                                                  : dosp_pkg::KIND_REMOTE;
      slast = ({1'b0, soff_ff} + 9'd1) == {1'b0, slen_ff};
      nsp = {1'b0, off} + 9'd1;
      if (in_valid) begin
         if (first_byte) begin
            phase_in = dosp_pkg::PH_IDLE; steps_in = '0; ocode_in = '0; olen_in = '0;
            ooff_in = '0; gath_in = '0; scode_in = '0; slen_in = '0; soff_in = '0;
            scnt_in = '0; sprn_in = 1'b1;
            plen_in = payload_len;
            strong_in = dest_port == server_port || dest_port == client_port;
            reqf_in = b == 8'd1;
            hdr_in = {24'd0, b};
            pos_in = 16'd1;
            if (!is_udp || payload_len < dosp_pkg::HEADER_BYTES || (b != 8'd1 && b != 8'd2)) begin
               res_valid_in = 1'b1;
               res_in.kind = dosp_pkg::KIND_VERDICT;
            end else begin
               phase_in = dosp_pkg::PH_HEAD;
            end
         end else if (phase_ff != dosp_pkg::PH_IDLE) begin
            if (p >= plen_ff) begin
               phase_in = dosp_pkg::PH_IDLE;
            end else begin
               pos_in = p + 16'd1;
               unique case (phase_ff)
                  dosp_pkg::PH_HEAD: begin
                     hdr_in = {hdr_ff[23:0], b};
                     if (p == dosp_pkg::COOKIE_LAST_POS) begin
                        res_valid_in = 1'b1;
                        res_in.kind = dosp_pkg::KIND_VERDICT;
                        if (hdr_in != dosp_pkg::MAGIC_COOKIE) begin
                           phase_in = dosp_pkg::PH_IDLE;
                        end else begin
                           phase_in = dosp_pkg::PH_TYPE;
                           steps_in = '0;
                           res_in.value = strong_ff ? 32'd2 : 32'd1;
                           res_in.aux_one = {7'd0, reqf_ff};
                        end
                     end
                  end
                  dosp_pkg::PH_TYPE: begin
                     if (steps_ff >= StepLimit) begin
                        phase_in = dosp_pkg::PH_IDLE;
                        res_valid_in = 1'b1;
                        res_in.kind = dosp_pkg::KIND_WARNING;
                        res_in.value = dosp_pkg::WARN_STEPS;
                     end else begin
                        steps_in = steps_ff + 8'd1;
                        if (b == dosp_pkg::OPT_PAD) begin
                        end else if (b == dosp_pkg::OPT_END) begin
                           phase_in = dosp_pkg::PH_IDLE;
                        end else if ({1'b0, p} + 17'd1 >= {1'b0, plen_ff}) begin
                           phase_in = dosp_pkg::PH_IDLE;
                           res_valid_in = 1'b1;
                           res_in.kind = dosp_pkg::KIND_WARNING;
                           res_in.value = dosp_pkg::WARN_TRUNC;
                        end else begin
                           ocode_in = b;
                           phase_in = dosp_pkg::PH_LEN;
                        end
                     end
                  end
                  dosp_pkg::PH_LEN: begin
                     if ({1'b0, p} + 17'd1 + {9'd0, b} > {1'b0, plen_ff}) begin
                        phase_in = dosp_pkg::PH_IDLE;
                        res_valid_in = 1'b1;
                        res_in.kind = dosp_pkg::KIND_WARNING;
                        res_in.value = dosp_pkg::WARN_OVERRUN;
                     end else begin
                        olen_in = b; ooff_in = '0; gath_in = '0;
                        if (b == 8'd0) begin
                           phase_in = dosp_pkg::PH_TYPE;
                           if (ocode_ff == dosp_pkg::OPT_HOST || ocode_ff == dosp_pkg::OPT_VENDOR) begin
                              res_valid_in = 1'b1;
                              res_in.kind = (ocode_ff == dosp_pkg::OPT_HOST) ?
                                 dosp_pkg::KIND_HOST : dosp_pkg::KIND_VENDOR;
                              res_in.empty_field = 1'b1;
                           end
                        end else if (ocode_ff == dosp_pkg::OPT_RELAY) begin
                           scnt_in = '0; scode_in = '0;
                           phase_in = (b >= 8'd2 && SubLimit != '0) ?
                              dosp_pkg::PH_RCODE : dosp_pkg::PH_RSKIP;
                        end else begin
                           phase_in = dosp_pkg::PH_VAL;
                        end
                     end
                  end
                  default: begin
                     ooff_in = off + 8'd1;
                     if (phase_ff == dosp_pkg::PH_VAL) begin
                        case (ocode_ff)
                           dosp_pkg::OPT_MSGTYPE: if (olen_ff == 8'd1) begin
                              res_valid_in = 1'b1;
                              res_in.kind = dosp_pkg::KIND_MSGTYPE;
                              res_in.value = {24'd0, b};
                           end
                           dosp_pkg::OPT_REQIP: if (olen_ff == 8'd4) begin
                              if (off < 8'd3) gath_in = {gath_ff[15:0], b};
                              else begin
                                 res_valid_in = 1'b1;
                                 res_in.kind = dosp_pkg::KIND_REQIP;
                                 res_in.value = {gath_ff, b};
                              end
                           end
                           dosp_pkg::OPT_HOST, dosp_pkg::OPT_VENDOR: begin
                              res_valid_in = 1'b1;
                              res_in.kind = (ocode_ff == dosp_pkg::OPT_HOST) ?
                                 dosp_pkg::KIND_HOST : dosp_pkg::KIND_VENDOR;
                              res_in.value = {24'd0, b};
                              res_in.byte_index = off;
                              res_in.last_of_field = last;
                           end
                           dosp_pkg::OPT_AUTH: if (olen_ff >= dosp_pkg::AUTH_MIN_LEN) begin
                              if (off < 8'd2) gath_in = {gath_ff[15:0], b};
                              else if (off == 8'd2) begin
                                 res_valid_in = 1'b1;
                                 res_in.kind = dosp_pkg::KIND_AUTHHDR;
                                 res_in.value = {24'd0, gath_ff[15:8]};
                                 res_in.aux_one = gath_ff[7:0];
                                 res_in.aux_two = b;
                              end else if (off <= 8'd10) begin
                                 res_valid_in = 1'b1;
                                 res_in.kind = dosp_pkg::KIND_REPLAY;
                                 res_in.value = {24'd0, b};
                                 res_in.byte_index = off - 8'd3;
                                 res_in.last_of_field = off == 8'd10;
                              end else begin
                                 res_valid_in = 1'b1;
                                 res_in.kind = dosp_pkg::KIND_AUTHINFO;
                                 res_in.value = {24'd0, b};
                                 res_in.byte_index = off - 8'd11;
                                 res_in.last_of_field = last;
                              end
                           end
                           default: ;
                        endcase
                     end else begin
                        case (phase_ff)
                           dosp_pkg::PH_RCODE: begin
                              scode_in = b;
                              phase_in = dosp_pkg::PH_RLEN;
                           end
                           dosp_pkg::PH_RLEN: begin
                              if ({1'b0, off} + 9'd1 + {1'b0, b} > {1'b0, olen_ff}) begin
                                 phase_in = dosp_pkg::PH_RSKIP;
                              end else begin
                                 slen_in = b; soff_in = '0; sprn_in = 1'b1;
                                 if (b == 8'd0) begin
                                    if (named) begin
                                       res_valid_in = 1'b1;
                                       res_in.kind = skind;
                                       res_in.empty_field = 1'b1;
                                    end
                                    scnt_in = scnt_ff + 1'b1;
                                    phase_in = (nsp + 9'd2 <= {1'b0, olen_ff} && scnt_in < SubLimit)
                                       ? dosp_pkg::PH_RCODE : dosp_pkg::PH_RSKIP;
                                 end else begin
                                    phase_in = dosp_pkg::PH_RVAL;
                                 end
                              end
                           end
                           dosp_pkg::PH_RVAL: begin
                              sprn_in = sprn_ff && b >= dosp_pkg::PRINT_LOW &&
                                        b <= dosp_pkg::PRINT_HIGH;
                              if (named) begin
                                 res_valid_in = 1'b1;
                                 res_in.kind = skind;
                                 res_in.value = {24'd0, b};
                                 res_in.byte_index = soff_ff;
                                 res_in.last_of_field = slast;
                                 res_in.printable = slast && sprn_in;
                              end
                              soff_in = soff_ff + 8'd1;
                              if (slast) begin
                                 scnt_in = scnt_ff + 1'b1;
                                 phase_in = (nsp + 9'd2 <= {1'b0, olen_ff} && scnt_in < SubLimit)
                                    ? dosp_pkg::PH_RCODE : dosp_pkg::PH_RSKIP;
                              end
                           end
                           default: ;
                        endcase
                     end
                     if (last) phase_in = dosp_pkg::PH_TYPE;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dosp_pkg::PH_IDLE; pos_ff <= '0; plen_ff <= '0; strong_ff <= 1'b0;
         reqf_ff <= 1'b0; sprn_ff <= 1'b1; hdr_ff <= '0; steps_ff <= '0; ocode_ff <= '0;
         olen_ff <= '0; ooff_ff <= '0; gath_ff <= '0; scode_ff <= '0; slen_ff <= '0;
         soff_ff <= '0; scnt_ff <= '0; res_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; plen_ff <= plen_in; strong_ff <= strong_in;
         reqf_ff <= reqf_in; sprn_ff <= sprn_in; hdr_ff <= hdr_in; steps_ff <= steps_in;
         ocode_ff <= ocode_in; olen_ff <= olen_in; ooff_ff <= ooff_in; gath_ff <= gath_in;
         scode_ff <= scode_in; slen_ff <= slen_in; soff_ff <= soff_in; scnt_ff <= scnt_in;
         res_valid_ff <= res_valid_in;
      end
      res_ff <= res_in;
   end
endmodule
`default_nettype wire

### hdl/dosp_skid.sv
// Two-entry output buffer decoupling the parse step from the result stall.
// Depends on dosp_pkg.
`default_nettype none
module dosp_skid (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  dosp_pkg::result_type in_res,
   output logic space,
   output logic out_valid,
   output dosp_pkg::result_type out_res,
   input  wire logic out_ready
);
   logic [1:0] cnt_ff;
   dosp_pkg::result_type buf_ff [2];
   logic pop;

   assign pop = out_valid && out_ready;
   assign out_valid = cnt_ff != 2'd0;
   assign out_res = buf_ff[0];
   // The parse register may hold one word in flight, so keep a slot for it;
   // a word leaving in this cycle frees its slot.
   assign space = cnt_ff == 2'd0 || (cnt_ff == 2'd1 && (!in_valid || pop)) ||
                  (cnt_ff == 2'd2 && !in_valid && pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, in_valid} - {1'b0, pop};
      end
      if (pop) begin
         if (cnt_ff == 2'd2) buf_ff[0] <= buf_ff[1];
         else buf_ff[0] <= in_res;
         if (cnt_ff == 2'd2 && in_valid) buf_ff[1] <= in_res;
      end else if (in_valid) begin
         buf_ff[cnt_ff[0]] <= in_res;
      end
   end
endmodule
`default_nettype wire

### hdl/dhcp_option_stream_parser_core.sv
// DHCP option stream parser: top level, config registers and assertions.
// Depends on dosp_pkg, dosp_parse, dosp_skid and the defines header.
//
// Usage: the req_ channel carries one payload byte per word; req_tuser[0]
// marks the first byte, which also samples length, port and UDP flag in
// req_tdata. The rsp_ channel gives at most one result word per accepted
// byte: first a verdict, then option values and warnings, in byte order.
// csr_ writes set server_port (index 0) and client_port (index 1); the user
// must write them only while idle, as the block itself does not enforce it.
// A result reaches rsp_ through the parse register, then the output buffer.
// Throughput: one byte per cycle while req_tready is high; the per-byte state
// update is one registered step. A two-word output buffer takes results while
// rsp_tready is low; req_tready falls when that buffer cannot take another
// word, and a word leaving on rsp_ frees a slot in the same cycle.
// Reset (synchronous, active high) drops any payload in progress, empties
// the buffer and sets the port registers to 67 and 68.
`default_nettype none
`include "dhcp_option_stream_parser_core_defines.svh"
module dhcp_option_stream_parser_core #(
   parameter int MAX_OPTION_STEPS = 200,
   parameter int MAX_SUBOPTIONS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // data_byte[7:0], payload_len[23:8], dest_port[39:24], is_udp[40], zero fill
   input  wire logic [47:0] req_tdata,
   // first_byte
   input  wire logic req_tuser,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // kind[3:0], value[35:4], aux_one[43:36], aux_two[51:44], byte_index[59:52],
   // last_of_field[60], empty_field[61], printable[62], zero fill
   output logic [63:0] rsp_tdata,
   input  wire logic csr_we,
   input  wire logic [0:0] csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam logic [0:0] RegServer = 1'b0;
   localparam logic [0:0] RegClient = 1'b1;

   logic [15:0] server_port_ff, client_port_ff;
   logic acc, res_valid;
   dosp_pkg::result_type res, out_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         server_port_ff <= 16'd67;
         client_port_ff <= 16'd68;
      end else if (csr_we) begin
         unique case (csr_index)
            RegServer: server_port_ff <= csr_wdata;
            RegClient: client_port_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign acc = req_tvalid && req_tready;

   dosp_parse #(.MAX_OPTION_STEPS(MAX_OPTION_STEPS), .MAX_SUBOPTIONS(MAX_SUBOPTIONS)) u_parse (
      .clock, .reset, .in_valid(acc),
      .data_byte(req_tdata[7:0]), .first_byte(req_tuser),
      .payload_len(req_tdata[23:8]), .dest_port(req_tdata[39:24]), .is_udp(req_tdata[40]),
      .server_port(server_port_ff), .client_port(client_port_ff),
      .res_valid, .res
   );

   dosp_skid u_skid (
      .clock, .reset, .in_valid(res_valid), .in_res(res), .space(req_tready),
      .out_valid(rsp_tvalid), .out_res, .out_ready(rsp_tready)
   );

   assign rsp_tdata = {1'b0, out_res.printable, out_res.empty_field, out_res.last_of_field,
                       out_res.byte_index, out_res.aux_two, out_res.aux_one,
                       out_res.value, out_res.kind};

   `DOSP_ASSERT_NXT(a_result_from_accept, clock, reset, !acc, !res_valid)
   `DOSP_ASSERT_IMP(a_kind_range, clock, reset, rsp_tvalid, out_res.kind <= dosp_pkg::KIND_WARNING)
   `DOSP_ASSERT_IMP(a_printable_on_last, clock, reset, rsp_tvalid && out_res.printable,
                    out_res.last_of_field)
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking bench for the DHCP option stream parser: feeds payload bytes,
// predicts each result word in a behavioral model and checks the rsp_ stream.
// Depends on dosp_pkg and the dhcp_option_stream_parser_core RTL.
`timescale 1ns / 100ps
module testbench;
   typedef logic [7:0] byte_list_type[$];

   localparam int STEP_LIMIT = 200;
   localparam int SUB_LIMIT = 8;
   localparam int ITEMS_BEFORE_TAIL = 1550;
   localparam logic [0:0] CSR_SERVER_PORT = 1'b0;
   localparam logic [0:0] CSR_CLIENT_PORT = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   dhcp_option_stream_parser_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [15:0] srv_port = 16'd67, cli_port = 16'd68;
   logic [15:0] pos, plen;
   logic port_hit, reqf, sprint;
   logic [31:0] hshift;
   dosp_pkg::phase_type ph;
   logic [7:0] steps, ocode, olen, ooff, scode, slen, soff;
   logic [23:0] gather;
   logic [3:0] scount;

   dosp_pkg::result_type expected_results[$];
   int errors = 0;
   int items_sent = 0;
   bit quiet = 0;
   bit idle_on = 1;
   bit hold_req = 0;

   function automatic dosp_pkg::result_type mk(logic [3:0] k, logic [31:0] v,
                                               logic [7:0] a1, logic [7:0] a2,
                                               logic [7:0] idx, logic lst,
                                               logic emp, logic prn);
      dosp_pkg::result_type r;
      r.kind = k; r.value = v; r.aux_one = a1; r.aux_two = a2;
      r.byte_index = idx; r.last_of_field = lst; r.empty_field = emp; r.printable = prn;
      return r;
   endfunction

   function automatic void clear_payload();
      pos = 0; plen = 0; port_hit = 0; hshift = 0; reqf = 0; ph = dosp_pkg::PH_IDLE;
      steps = 0; ocode = 0; olen = 0; ooff = 0; gather = 0;
      scode = 0; slen = 0; soff = 0; scount = 0; sprint = 1;
   endfunction

   function automatic void pick_sub(int next_sp);
      if (next_sp + 2 <= int'(olen) && int'(scount) < SUB_LIMIT) ph = dosp_pkg::PH_RCODE;
      else ph = dosp_pkg::PH_RSKIP;
   endfunction

   // advance the model by one byte; returns 1 when a result word is due
   function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                     input logic [15:0] len, input logic [15:0] port,
                                     input logic udp, output dosp_pkg::result_type r);
      int p, off;
      bit last, lastsub, named;
      logic [3:0] sk;
      r = '0;
      if (first) begin
         clear_payload();
         plen = len;
         port_hit = (port == srv_port || port == cli_port);
         reqf = (b == 8'd1);
         hshift = {24'd0, b};
         pos = 1;
         if (!udp || len < dosp_pkg::HEADER_BYTES || (b != 8'd1 && b != 8'd2)) begin
            r = mk(dosp_pkg::KIND_VERDICT, 0, 0, 0, 0, 0, 0, 0);
            return 1;
         end
         ph = dosp_pkg::PH_HEAD;
         return 0;
      end
      if (ph == dosp_pkg::PH_IDLE) return 0;
      p = int'(pos);
      if (p >= int'(plen)) begin
         ph = dosp_pkg::PH_IDLE;
         return 0;
      end
      pos = 16'(p + 1);
      case (ph)
         dosp_pkg::PH_HEAD: begin
            hshift = {hshift[23:0], b};
            if (p == int'(dosp_pkg::COOKIE_LAST_POS)) begin
               if (hshift != dosp_pkg::MAGIC_COOKIE) begin
                  ph = dosp_pkg::PH_IDLE;
                  r = mk(dosp_pkg::KIND_VERDICT, 0, 0, 0, 0, 0, 0, 0);
                  return 1;
               end
               ph = dosp_pkg::PH_TYPE;
               steps = 0;
               r = mk(dosp_pkg::KIND_VERDICT, 32'd1 + {31'd0, port_hit}, {7'd0, reqf},
                      0, 0, 0, 0, 0);
               return 1;
            end
            return 0;
         end
         dosp_pkg::PH_TYPE: begin
            if (int'(steps) >= STEP_LIMIT) begin
               ph = dosp_pkg::PH_IDLE;
               r = mk(dosp_pkg::KIND_WARNING, dosp_pkg::WARN_STEPS, 0, 0, 0, 0, 0, 0);
               return 1;
            end
            steps = steps + 8'd1;
            if (b == dosp_pkg::OPT_PAD) return 0;
            if (b == dosp_pkg::OPT_END) begin
               ph = dosp_pkg::PH_IDLE;
               return 0;
            end
            if (p + 1 >= int'(plen)) begin
               ph = dosp_pkg::PH_IDLE;
               r = mk(dosp_pkg::KIND_WARNING, dosp_pkg::WARN_TRUNC, 0, 0, 0, 0, 0, 0);
               return 1;
            end
            ocode = b;
            ph = dosp_pkg::PH_LEN;
            return 0;
         end
         dosp_pkg::PH_LEN: begin
            if (p + 1 + int'(b) > int'(plen)) begin
               ph = dosp_pkg::PH_IDLE;
               r = mk(dosp_pkg::KIND_WARNING, dosp_pkg::WARN_OVERRUN, 0, 0, 0, 0, 0, 0);
               return 1;
            end
            olen = b; ooff = 0; gather = 0;
            if (b == 8'd0) begin
               ph = dosp_pkg::PH_TYPE;
               if (ocode == dosp_pkg::OPT_HOST || ocode == dosp_pkg::OPT_VENDOR) begin
                  r = mk(ocode == dosp_pkg::OPT_HOST ? dosp_pkg::KIND_HOST
                                                     : dosp_pkg::KIND_VENDOR,
                         0, 0, 0, 0, 0, 1, 0);
                  return 1;
               end
               return 0;
            end
            if (ocode == dosp_pkg::OPT_RELAY) begin
               scount = 0; scode = 0;
               pick_sub(0);
            end else begin
               ph = dosp_pkg::PH_VAL;
            end
            return 0;
         end
         default: begin
            parse_byte = 0;
            off = int'(ooff);
            last = (off + 1 >= int'(olen));
            ooff = ooff + 8'd1;
            if (ph == dosp_pkg::PH_VAL) begin
               case (ocode)
                  dosp_pkg::OPT_MSGTYPE:
                     if (olen == 8'd1) begin
                        r = mk(dosp_pkg::KIND_MSGTYPE, {24'd0, b}, 0, 0, 0, 0, 0, 0);
                        parse_byte = 1;
                     end
                  dosp_pkg::OPT_REQIP:
                     if (olen == 8'd4) begin
                        if (off < 3) gather = {gather[15:0], b};
                        else begin
                           r = mk(dosp_pkg::KIND_REQIP, {gather, b}, 0, 0, 0, 0, 0, 0);
                           parse_byte = 1;
                        end
                     end
                  dosp_pkg::OPT_HOST, dosp_pkg::OPT_VENDOR: begin
                     r = mk(ocode == dosp_pkg::OPT_HOST ? dosp_pkg::KIND_HOST
                                                        : dosp_pkg::KIND_VENDOR,
                            {24'd0, b}, 0, 0, 8'(off), last, 0, 0);
                     parse_byte = 1;
                  end
                  dosp_pkg::OPT_AUTH:
                     if (olen >= dosp_pkg::AUTH_MIN_LEN) begin
                        if (off < 2) gather = {gather[15:0], b};
                        else begin
                           parse_byte = 1;
                           if (off == 2)
                              r = mk(dosp_pkg::KIND_AUTHHDR, {24'd0, gather[15:8]},
                                     gather[7:0], b, 0, 0, 0, 0);
                           else if (off <= 10)
                              r = mk(dosp_pkg::KIND_REPLAY, {24'd0, b}, 0, 0, 8'(off - 3),
                                     off == 10, 0, 0);
                           else
                              r = mk(dosp_pkg::KIND_AUTHINFO, {24'd0, b}, 0, 0,
                                     8'(off - 11), last, 0, 0);
                        end
                     end
                  default: ;
               endcase
            end else begin
               named = (scode == dosp_pkg::SUB_CIRCUIT || scode == dosp_pkg::SUB_REMOTE);
               sk = (scode == dosp_pkg::SUB_CIRCUIT) ? dosp_pkg::KIND_CIRCUIT
                                                     : dosp_pkg::KIND_REMOTE;
               case (ph)
                  dosp_pkg::PH_RCODE: begin
                     scode = b;
                     ph = dosp_pkg::PH_RLEN;
                  end
                  dosp_pkg::PH_RLEN:
                     if ((off - 1) + 2 + int'(b) > int'(olen)) ph = dosp_pkg::PH_RSKIP;
                     else begin
                        slen = b; soff = 0; sprint = 1;
                        if (b == 8'd0) begin
                           if (named) begin
                              r = mk(sk, 0, 0, 0, 0, 0, 1, 0);
                              parse_byte = 1;
                           end
                           scount = scount + 4'd1;
                           pick_sub(off + 1);
                        end else begin
                           ph = dosp_pkg::PH_RVAL;
                        end
                     end
                  dosp_pkg::PH_RVAL: begin
                     lastsub = (int'(soff) + 1 == int'(slen));
                     if (b < dosp_pkg::PRINT_LOW || b > dosp_pkg::PRINT_HIGH) sprint = 0;
                     if (named) begin
                        r = mk(sk, {24'd0, b}, 0, 0, soff, lastsub, 0,
                               lastsub ? sprint : 1'b0);
                        parse_byte = 1;
                     end
                     soff = soff + 8'd1;
                     if (lastsub) begin
                        scount = scount + 4'd1;
                        pick_sub(off + 1);
                     end
                  end
                  default: ;
               endcase
            end
            if (last) ph = dosp_pkg::PH_TYPE;
         end
      endcase
   endfunction

   // sender: one word per call, tvalid stays high on return
   task automatic send_word(input logic [7:0] d, input logic first,
                            input logic [15:0] len, input logic [15:0] port,
                            input logic udp);
      dosp_pkg::result_type r;
      if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tdata <= {7'd0, udp, port, len, d};
      req_tuser <= first;
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      items_sent++;
      if (parse_byte(d, first, len, port, udp, r)) expected_results.push_back(r);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [15:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SERVER_PORT) srv_port = val;
      else cli_port = val;
   endtask

   function automatic logic [7:0] text_byte();
      case ($urandom_range(0, 5))
         0: return 8'h1F;
         1: return 8'h7F;
         2: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   function automatic void add_field(ref byte_list_type q, input logic [7:0] code,
                                     input int n, input bit text);
      q.push_back(code);
      q.push_back(8'(n));
      repeat (n) q.push_back(text ? text_byte() : 8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_relay(ref byte_list_type q);
      byte_list_type s;
      int n;
      repeat ($urandom_range(0, 10)) begin
         case ($urandom_range(0, 4))
            0, 1: s.push_back(dosp_pkg::SUB_CIRCUIT);
            2: s.push_back(dosp_pkg::SUB_REMOTE);
            3: s.push_back(dosp_pkg::SUB_REMOTE);
            default: s.push_back(8'($urandom_range(0, 255)));
         endcase
         n = $urandom_range(0, 8);
         // occasionally claim more than the option holds
         s.push_back(8'($urandom_range(0, 9) == 0 ? $urandom_range(9, 255) : n));
         repeat (n) s.push_back(text_byte());
      end
      if ($urandom_range(0, 4) == 0) s.push_back(dosp_pkg::SUB_CIRCUIT);
      while (s.size() > 255) void'(s.pop_back());
      q.push_back(dosp_pkg::OPT_RELAY);
      q.push_back(8'(s.size()));
      foreach (s[i]) q.push_back(s[i]);
   endfunction

   function automatic byte_list_type make_options(input int target);
      byte_list_type q;
      while (q.size() < target) begin
         case ($urandom_range(0, 19))
            0, 1: q.push_back(dosp_pkg::OPT_PAD);
            2: q.push_back(dosp_pkg::OPT_END);
            3, 4: add_field(q, dosp_pkg::OPT_MSGTYPE,
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 1, 0);
            5, 6: add_field(q, dosp_pkg::OPT_REQIP,
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 4, 0);
            7, 8: add_field(q, dosp_pkg::OPT_HOST, $urandom_range(0, 20), 1);
            9: add_field(q, dosp_pkg::OPT_VENDOR, $urandom_range(0, 20), 1);
            10, 11: add_field(q, dosp_pkg::OPT_AUTH,
                              $urandom_range(0, 3) == 0 ? $urandom_range(0, 10)
                                                        : $urandom_range(11, 24), 0);
            12, 13, 14, 15: add_relay(q);
            default: add_field(q, 8'($urandom_range(1, 254)), $urandom_range(0, 10), 0);
         endcase
      end
      return q;
   endfunction

   // full payload: header, cookie, options; len_adj shifts the claimed length
   task automatic send_payload(input logic [7:0] op, input bit good_cookie,
                               input byte_list_type opts, input int len_adj,
                               input logic [15:0] port);
      byte_list_type pl;
      int len, n;
      logic [31:0] cookie;
      cookie = good_cookie ? dosp_pkg::MAGIC_COOKIE
                           : dosp_pkg::MAGIC_COOKIE ^ (32'd1 << $urandom_range(0, 31));
      pl.push_back(op);
      repeat (235) pl.push_back(8'($urandom_range(0, 255)));
      for (int i = 3; i >= 0; i--) pl.push_back(cookie[8*i +: 8]);
      foreach (opts[i]) pl.push_back(opts[i]);
      len = pl.size() + len_adj;
      if (len < 0) len = 0;
      if (len > 65535) len = 65535;
      n = (len < pl.size()) ? len : pl.size();
      if (n < 1) n = 1;
      n += $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
         send_word(i < pl.size() ? pl[i] : 8'($urandom_range(0, 255)), i == 0,
                   16'(len), port, 1'b1);
   endtask

   function automatic int random_adj();
      case ($urandom_range(0, 5))
         0: return -int'($urandom_range(1, 20));
         1: return int'($urandom_range(1, 4));
         default: return 0;
      endcase
   endfunction

   task automatic test_short_headers();
      send_word(8'd1, 1, 16'd300, 16'd67, 1'b0);
      send_word(8'd2, 1, 16'd239, 16'd68, 1'b1);
      send_word(8'd1, 1, 16'd0, 16'hFFFF, 1'b1);
      send_word(8'd0, 1, 16'hFFFF, 16'd0, 1'b1);
      send_word(8'd3, 1, 16'hFFFF, 16'hAAAA, 1'b1);
      send_word(8'hFF, 1, 16'h5555, 16'h5555, 1'b1);
      send_word(8'h5A, 0, 16'h0, 16'h0, 1'b0);
      send_word(8'hA5, 0, 16'hFFFF, 16'hFFFF, 1'b1);
      // start a valid header, then abandon it
      send_word(8'd2, 1, 16'hFFFF, 16'hFFFF, 1'b1);
      send_word(8'h63, 0, 16'h0, 16'h0, 1'b0);
      send_word(8'd1, 1, 16'd240, 16'd67, 1'b1);
      send_word(8'd7, 1, 16'd240, 16'd67, 1'b0);
      repeat (8)
         send_word(8'($urandom_range(0, 255)), 1, 16'($urandom), 16'($urandom),
                   1'($urandom));
   endtask

   task automatic test_port_registers();
      byte_list_type none;
      write_csr(CSR_SERVER_PORT, 16'h0000);
      write_csr(CSR_CLIENT_PORT, 16'hFFFF);
      send_payload(8'd2, 1, none, 0, 16'hFFFF);
      write_csr(CSR_SERVER_PORT, 16'd67);
      write_csr(CSR_CLIENT_PORT, 16'd68);
   endtask

   task automatic test_step_limit();
      byte_list_type q;
      repeat (210) q.push_back(dosp_pkg::OPT_PAD);
      send_payload(8'd2, 1, q, 0, 16'd1);
   endtask

   task automatic test_truncation();
      byte_list_type q;
      add_field(q, dosp_pkg::OPT_HOST, 0, 1);
      add_field(q, dosp_pkg::OPT_VENDOR, 0, 1);
      q.push_back(dosp_pkg::OPT_HOST);
      send_payload(8'd1, 1, q, 0, 16'd2);
   endtask

   task automatic test_backpressure();
      byte_list_type q;
      add_field(q, dosp_pkg::OPT_HOST, 60, 1);
      add_field(q, dosp_pkg::OPT_AUTH, 30, 0);
      drain();
      hold_req = 1;
      send_payload(8'd1, 1, q, 0, srv_port);
      // pause until every result is back
      drain();
   endtask

   task automatic test_random_payloads();
      while (items_sent < ITEMS_BEFORE_TAIL) begin
         idle_on = $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 15))
            0: begin
               write_csr(1'($urandom), 16'($urandom));
            end
            1, 2:
               repeat ($urandom_range(1, 6))
                  send_word(8'($urandom_range(0, 255)), 1'($urandom), 16'($urandom),
                            16'($urandom), 1'($urandom));
            default:
               send_payload(8'($urandom_range(1, 2)), $urandom_range(0, 9) != 0,
                            make_options($urandom_range(0, 60)), random_adj(),
                            $urandom_range(0, 2) == 0 ? 16'($urandom) :
                            ($urandom_range(0, 1) ? srv_port : cli_port));
         endcase
      end
   endtask

   task automatic test_quiet_tail();
      quiet = 1;
      send_payload(8'd2, 1, make_options(20), 0, cli_port);
   endtask

   // receiver: random ready bursts, one long hold-off on request
   int rsp_burst = 0;
   bit rsp_stall = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req = 0;
         hold_left = 150;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         if (rsp_burst == 0) begin
            rsp_stall = ($urandom_range(0, 2) == 0);
            rsp_burst = $urandom_range(1, 8);
         end
         rsp_burst--;
         rsp_tready <= !rsp_stall;
      end
   end

   // sampled at the falling edge; the word moves at the next rising edge
   always @(negedge clock) begin
      dosp_pkg::result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tdata[3:0];
         got.value = rsp_tdata[35:4];
         got.aux_one = rsp_tdata[43:36];
         got.aux_two = rsp_tdata[51:44];
         got.byte_index = rsp_tdata[59:52];
         got.last_of_field = rsp_tdata[60];
         got.empty_field = rsp_tdata[61];
         got.printable = rsp_tdata[62];
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: kind %0d/%0d value %h/%h aux %h %h/%h %h ",
                            "idx %0d/%0d flags %b%b%b/%b%b%b"},
                           want.kind, got.kind, want.value, got.value, want.aux_one,
                           want.aux_two, got.aux_one, got.aux_two, want.byte_index,
                           got.byte_index, want.last_of_field, want.empty_field,
                           want.printable, got.last_of_field, got.empty_field,
                           got.printable);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      clear_payload();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_headers();
      test_port_registers();
      test_step_limit();
      test_truncation();
      test_backpressure();
      test_random_payloads();
      test_quiet_tail();
      drain();
      repeat (10) @(posedge clock);
      if (errors == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end
endmodule
